[rtl/ghbp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ghbp_pkg: shared types and constants of the global history branch predictor
// Table geometry, counter widths, register indexes and the table write request.
// ----------------------------------------------------------------------------
package ghbp_pkg;

  // Table geometry
  localparam int INDEX_BITS   = 12;
  localparam int COUNTER_BITS = 2;
  localparam int TABLE_DEPTH  = 1 << INDEX_BITS;

  // Field and register widths
  localparam int PC_BITS       = 32;
  localparam int HIST_BITS     = 12;
  localparam int SHIFT_BITS    = 4;
  localparam int CREG_BITS     = 2;
  localparam int CFG_IDX_BITS  = 8;
  localparam int CFG_DATA_BITS = 12;

  // Counters are compared against 2-bit registers in a common width
  localparam int CMP_BITS      = (COUNTER_BITS > CREG_BITS) ? COUNTER_BITS : CREG_BITS;
  localparam int COUNTER_LIMIT = (1 << COUNTER_BITS) - 1;

  // Register reset values
  localparam int CFG_PC_SHIFT_RST     = 6;
  localparam int CFG_HIST_MASK_RST    = 63;
  localparam int CFG_COUNTER_MAX_RST  = 3;
  localparam int CFG_COUNTER_MID_RST  = 1;

  // Reset fill: reset ceiling clamped to the counter width
  localparam int FILL_INT = (CFG_COUNTER_MAX_RST < COUNTER_LIMIT) ?
                            CFG_COUNTER_MAX_RST : COUNTER_LIMIT;
  localparam logic [COUNTER_BITS-1:0] COUNTER_FILL = COUNTER_BITS'(FILL_INT);

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_PC_SHIFT    = 8'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_HIST_MASK   = 8'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_COUNTER_MAX = 8'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_COUNTER_MID = 8'd3;

  // Item operations
  localparam logic OP_PREDICT = 1'b0;
  localparam logic OP_TRAIN   = 1'b1;

  // Counter table write request
  typedef struct packed {
    logic                    en;
    logic [INDEX_BITS-1:0]   idx;
    logic [COUNTER_BITS-1:0] data;
  } ghbp_wr_t;

  // Counter table read request
  typedef struct packed {
    logic                  en;
    logic [INDEX_BITS-1:0] idx;
  } ghbp_rd_t;

endpackage
`default_nettype wire

[rtl/global_history_branch_predictor.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// global_history_branch_predictor: gselect predictor with 2-bit counters
// Index = low INDEX_BITS of (pc << pc_shift) OR (history AND history_mask).
//
// Usage:
//   in_*  : one item per handshake; op selects predict only or predict+train.
//   out_* : one prediction per item, in order, read before any update.
//   cfg_* : register writes (index, data); always ready, write while idle.
// Timing:
//   An item reads the counter table at its accept edge; its result passes the
//   read stage and the result register. One item per cycle is sustained while
//   out_ready is high and no fill pass runs; the counter read-modify-write is
//   the critical loop, closed by a one-entry bypass of the last table write.
// Reset:
//   History clears to zero, registers take their reset values, and a fill
//   pass writes the reset counter value into all TABLE_DEPTH entries, one per
//   cycle. in_ready stays low meanwhile; configuration writes are still taken.
// Stall:
//   When out_ready is low with a result pending, the pipeline holds and
//   in_ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module global_history_branch_predictor (
  input  wire                                   clk,
  input  wire                                   rst_n,
  // Input items
  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  wire                                   in_op,
  input  wire  [ghbp_pkg::PC_BITS-1:0]          in_pc,
  input  wire                                   in_taken,
  // Results
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output logic                                  out_predict_taken,
  // Configuration writes
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire  [ghbp_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  wire  [ghbp_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);
  import ghbp_pkg::*;

  // Configuration registers
  logic [SHIFT_BITS-1:0] pc_shift_r;
  logic [HIST_BITS-1:0]  hist_mask_r;
  logic [CREG_BITS-1:0]  counter_max_r;
  logic [CREG_BITS-1:0]  counter_mid_r;

  // Global history
  logic [HIST_BITS-1:0]  history_r;
  logic [HIST_BITS-1:0]  history_nxt;

  // Read stage
  logic                  s1_valid_r;
  logic                  s1_op_r;
  logic                  s1_taken_r;

  // Result register
  logic                  out_valid_r;
  logic                  out_pred_r;

  // Datapath
  logic                    advance;
  logic                    in_acc;
  logic [PC_BITS-1:0]      pc_shifted;
  logic [PC_BITS-1:0]      index_word;
  logic [INDEX_BITS-1:0]   in_idx;
  logic [INDEX_BITS-1:0]   s1_idx_r;
  logic [COUNTER_BITS-1:0] ctr;
  logic [COUNTER_BITS-1:0] ctr_nxt;
  logic [CMP_BITS-1:0]     ceiling;
  logic                    pred;
  logic                    tbl_busy;
  ghbp_rd_t                rd_req;
  ghbp_wr_t                wr_req;

  // Handshake
  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = advance && !tbl_busy;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Configuration writes; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_shift_r    <= SHIFT_BITS'(CFG_PC_SHIFT_RST);
      hist_mask_r   <= HIST_BITS'(CFG_HIST_MASK_RST);
      counter_max_r <= CREG_BITS'(CFG_COUNTER_MAX_RST);
      counter_mid_r <= CREG_BITS'(CFG_COUNTER_MID_RST);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PC_SHIFT:    pc_shift_r    <= cfg_wdata[SHIFT_BITS-1:0];
        REG_HIST_MASK:   hist_mask_r   <= cfg_wdata[HIST_BITS-1:0];
        REG_COUNTER_MAX: counter_max_r <= cfg_wdata[CREG_BITS-1:0];
        REG_COUNTER_MID: counter_mid_r <= cfg_wdata[CREG_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Table index: shifted pc merged with masked history
  assign pc_shifted = in_pc << pc_shift_r;
  assign index_word = pc_shifted | PC_BITS'(history_r & hist_mask_r);
  assign in_idx     = index_word[INDEX_BITS-1:0];

  // History shifts on every accepted train item
  always_comb begin
    history_nxt = history_r;
    if (in_acc && (in_op == OP_TRAIN)) begin
      history_nxt = {history_r[HIST_BITS-2:0], in_taken};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      history_r <= '0;
    end else begin
      history_r <= history_nxt;
    end
  end

  // Table lookup issued at accept
  assign rd_req.en  = in_acc;
  assign rd_req.idx = in_idx;

  // Read stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r    <= in_op;
      s1_taken_r <= in_taken;
      s1_idx_r   <= in_idx;
    end
  end

  // Prediction and saturating update
  assign ceiling = (CMP_BITS'(counter_max_r) < CMP_BITS'(COUNTER_LIMIT)) ?
                   CMP_BITS'(counter_max_r) : CMP_BITS'(COUNTER_LIMIT);
  assign pred    = CMP_BITS'(ctr) > CMP_BITS'(counter_mid_r);

  always_comb begin
    ctr_nxt = ctr;
    if (s1_taken_r) begin
      if (CMP_BITS'(ctr) < ceiling) begin
        ctr_nxt = ctr + 1'b1;
      end
    end else begin
      if (ctr != '0) begin
        ctr_nxt = ctr - 1'b1;
      end
    end
  end

  assign wr_req.en   = s1_valid_r && advance && (s1_op_r == OP_TRAIN);
  assign wr_req.idx  = s1_idx_r;
  assign wr_req.data = ctr_nxt;

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_pred_r <= pred;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_predict_taken = out_pred_r;

  ghbp_ctr_table u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_req (rd_req),
    .wr_req (wr_req),
    .rd_ctr (ctr),
    .busy   (tbl_busy)
  );

  // A looked-up item always reaches the read stage
  a_acc_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_valid_r)
    else $error("accepted item missing from read stage");

  // A stalled read stage keeps its item
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r && $stable(s1_idx_r))
    else $error("read stage lost its item under stall");

  // History moves only on an accepted train item
  a_hist_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_acc && (in_op == OP_TRAIN)) |=> $stable(history_r))
    else $error("history changed without a train item");

  // No item is accepted during the fill pass
  a_no_acc_fill: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_busy |-> !in_acc && !s1_valid_r)
    else $error("item in flight during fill pass");

endmodule
`default_nettype wire

[rtl/ghbp_ctr_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ghbp_ctr_table: counter table with reset fill and write bypass
// One read and one write port, registered read data. After reset a fill pass
// writes the reset value into every entry, one per cycle. The most recent
// write is forwarded over a read issued at the same edge.
// ----------------------------------------------------------------------------
module ghbp_ctr_table (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire  ghbp_pkg::ghbp_rd_t            rd_req,
  input  wire  ghbp_pkg::ghbp_wr_t            wr_req,
  output logic [ghbp_pkg::COUNTER_BITS-1:0]   rd_ctr,
  output logic                                busy
);
  import ghbp_pkg::*;

  logic [COUNTER_BITS-1:0] mem [TABLE_DEPTH];
  logic [COUNTER_BITS-1:0] rd_data_r;
  logic [INDEX_BITS-1:0]   rd_idx_r;

  logic                    fill_busy_r;
  logic [INDEX_BITS-1:0]   fill_idx_r;

  logic                    byp_valid_r;
  logic [INDEX_BITS-1:0]   byp_idx_r;
  logic [COUNTER_BITS-1:0] byp_data_r;

  // Fill pass control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_busy_r <= 1'b1;
      fill_idx_r  <= '0;
    end else if (fill_busy_r) begin
      fill_idx_r <= fill_idx_r + 1'b1;
      if (fill_idx_r == INDEX_BITS'(TABLE_DEPTH - 1)) begin
        fill_busy_r <= 1'b0;
      end
    end
  end

  // Memory write port: fill pass first, then training updates
  always_ff @(posedge clk) begin
    if (fill_busy_r) begin
      mem[fill_idx_r] <= COUNTER_FILL;
    end else if (wr_req.en) begin
      mem[wr_req.idx] <= wr_req.data;
    end
  end

  // Memory read port
  always_ff @(posedge clk) begin
    if (rd_req.en) begin
      rd_data_r <= mem[rd_req.idx];
      rd_idx_r  <= rd_req.idx;
    end
  end

  // Last write, forwarded over a read taken at the same edge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_valid_r <= 1'b0;
    end else if (wr_req.en && !fill_busy_r) begin
      byp_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_req.en && !fill_busy_r) begin
      byp_idx_r  <= wr_req.idx;
      byp_data_r <= wr_req.data;
    end
  end

  assign rd_ctr = (byp_valid_r && (byp_idx_r == rd_idx_r)) ? byp_data_r : rd_data_r;
  assign busy   = fill_busy_r;

  // Once the fill pass ends it never restarts
  a_fill_once: assert property (@(posedge clk) disable iff (!rst_n)
    !fill_busy_r |=> !fill_busy_r)
    else $error("fill pass restarted");

  // No bypass entry can exist before the table is filled
  a_byp_after_fill: assert property (@(posedge clk) disable iff (!rst_n)
    fill_busy_r |-> !byp_valid_r)
    else $error("bypass valid during fill pass");

  // No lookup or update competes with the fill pass
  a_no_access_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
    fill_busy_r |-> !rd_req.en && !wr_req.en)
    else $error("table access during fill pass");

endmodule
`default_nettype wire
